// File: rtl/core/assert_macros.svh
// Assertion macros shared by the event state machine RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define TDEF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define TDEF_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/tdef_pkg.sv
// Types, codes and defaults for the table driven event state machine.
// No dependencies; imported by every module of the block.
package tdef_pkg;

    localparam int NUM_RULES_DEF = 16;
    localparam int NUM_TIMED_DEF = 8;

    typedef enum logic [2:0] {
        OP_LOAD_RULE  = 3'd0,
        OP_LOAD_TIMED = 3'd1,
        OP_FIRE       = 3'd2,
        OP_QUEUE      = 3'd3,
        OP_RUN        = 3'd4,
        OP_QUERY      = 3'd5,
        OP_REARM      = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        KIND_FIRST = 2'd0,
        KIND_ACT   = 2'd1,
        KIND_TRANS = 2'd2,
        KIND_QUERY = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        REG_INIT_STATE = 2'd0,
        REG_RULES      = 2'd1,
        REG_TIMED      = 2'd2
    } t_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_SRCH_RD,
        S_SRCH_EV,
        S_SDONE,
        S_ACT,
        S_PEND_RD,
        S_PEND_EV,
        S_TSCAN_RD,
        S_TSCAN_EV,
        S_TZERO,
        S_SWP_RD,
        S_SWP_EV,
        S_FLUSH
    } t_state;

    // where a re-arm sweep goes when it finishes
    typedef enum logic [1:0] {
        RET_DONE,
        RET_TSCAN,
        RET_TZERO
    } t_ret;

    typedef struct packed {
        logic [3:0] src;
        logic [3:0] tgt;
        logic [7:0] ev;
    } t_rule;

    typedef struct packed {
        logic [3:0]  src;
        logic [3:0]  tgt;
        logic [31:0] delay;
    } t_tcfg;

    typedef struct packed {
        logic [3:0] init_state;
        logic [4:0] rule_cnt;
        logic [3:0] timed_cnt;
    } t_cfg;

    typedef struct packed {
        t_kind      kind;
        logic [3:0] left;
        logic [3:0] entered;
        logic [3:0] slot;
        logic       timed;
        logic       answer;
        logic [3:0] present;
        logic       last;
    } t_result;

endpackage

// File: rtl/core/table_driven_event_fsm_unit.sv
// Top level of the table driven event state machine: sequencer, result path.
// Depends on tdef_pkg, tdef_cfg_regs, tdef_rule_mem, tdef_timed_mem.
//
// Usage: an item is taken on a rising edge with start high and busy low.
// Loads write one table slot; fire, queue and query search the event rules
// in slot order; run reports first entry and state activity, takes a queued
// rule and then checks each timed rule; rearm restarts matching timers.
// Results leave one per cycle on o_result_valid; the last result of an item
// carries o_last. The receiver cannot stall, so nothing is held back.
// Table access: every visit is a read step and then an evaluate step on the
// single read port of the table. Each transition adds a re-arm sweep of the
// timed table, a queued rule a fetch of its slot, a timed rule a disarm step.
// Each result is held one step so the final one can carry o_last.
// Reset: synchronous, active low; state, counts and timers clear at once,
// the tables hold no contents until loaded. Configure only while idle.
module table_driven_event_fsm_unit
    import tdef_pkg::*;
#(
    parameter int NUM_RULES = NUM_RULES_DEF,
    parameter int NUM_TIMED = NUM_TIMED_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_op,
    input  logic [31:0] i_now_ms,
    input  logic [7:0]  i_event_code,
    input  logic [3:0]  i_entry_index,
    input  logic [3:0]  i_from_state,
    input  logic [3:0]  i_to_state,
    input  logic [31:0] i_interval_ms,
    input  logic        i_any_target,
    output logic        o_result_valid,
    output logic [1:0]  o_kind,
    output logic [3:0]  o_left_state,
    output logic [3:0]  o_entered_state,
    output logic [3:0]  o_rule_slot,
    output logic        o_was_timed,
    output logic        o_answer,
    output logic [3:0]  o_present_state,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

`include "assert_macros.svh"

    localparam int RAW = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
    localparam int TAW = (NUM_TIMED > 1) ? $clog2(NUM_TIMED) : 1;
    localparam int RCW = $clog2(NUM_RULES + 1);
    localparam int TCW = $clog2(NUM_TIMED + 1);

    t_cfg cfg;
    logic init_we;

    tdef_cfg_regs u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_cfg     (cfg),
        .o_init_we (init_we)
    );

    // item registers
    t_op         r_op, n_op;
    logic [31:0] r_now, n_now;
    logic [7:0]  r_ev, n_ev;
    logic [3:0]  r_idx, n_idx;
    logic [3:0]  r_from, n_from;
    logic [3:0]  r_to, n_to;
    logic [31:0] r_ivl, n_ivl;
    logic        r_any, n_any;

    // control
    t_state         r_state, n_state;
    t_ret           r_ret, n_ret;
    logic [3:0]     r_cur, n_cur;
    logic           r_started, n_started;
    logic           r_pend_vld, n_pend_vld;
    logic [RAW-1:0] r_pend_slot, n_pend_slot;
    logic [RCW-1:0] r_ri, n_ri;
    logic [TCW-1:0] r_ti, n_ti;
    logic [TCW-1:0] r_tj, n_tj;
    logic           r_hit, n_hit;
    t_rule          r_hit_rule, n_hit_rule;
    logic [RAW-1:0] r_hit_slot, n_hit_slot;
    logic           r_hold_vld, n_hold_vld;
    t_result        r_hold, n_hold;
    logic           r_out_vld, n_out_vld;
    t_result        r_out, n_out;

    logic [RCW-1:0] rcnt;
    logic [TCW-1:0] tcnt;

    // memory ports
    logic           rule_we;
    logic [RAW-1:0] rule_raddr;
    t_rule          rule_wdata, rule_rdata;
    logic           tcfg_we, tstart_we;
    logic [TAW-1:0] t_waddr, t_raddr;
    t_tcfg          tcfg_wdata, tcfg_rdata;
    logic [31:0]    tstart_wdata, tstart_rdata;

    // helpers inside the next-state block
    logic           do_goto;
    logic [3:0]     g_src, g_tgt, g_slot;
    logic           g_timed;
    t_ret           g_ret;
    logic           e_req;
    t_result        e_res;
    logic [31:0]    elapsed;

    tdef_rule_mem #(.NUM_RULES(NUM_RULES)) u_rule_mem (
        .i_clk   (i_clk),
        .i_we    (rule_we),
        .i_waddr (RAW'(r_idx)),
        .i_wdata (rule_wdata),
        .i_raddr (rule_raddr),
        .o_rdata (rule_rdata)
    );

    tdef_timed_mem #(.NUM_TIMED(NUM_TIMED)) u_timed_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (tcfg_we),
        .i_start_we (tstart_we),
        .i_waddr    (t_waddr),
        .i_wcfg     (tcfg_wdata),
        .i_wstart   (tstart_wdata),
        .i_raddr    (t_raddr),
        .o_rcfg     (tcfg_rdata),
        .o_rstart   (tstart_rdata)
    );

    always_comb begin
        if (32'(cfg.rule_cnt) >= NUM_RULES) rcnt = RCW'(NUM_RULES);
        else                                rcnt = RCW'(cfg.rule_cnt);
        if (32'(cfg.timed_cnt) >= NUM_TIMED) tcnt = TCW'(NUM_TIMED);
        else                                 tcnt = TCW'(cfg.timed_cnt);
    end

    assign busy       = (r_state != S_IDLE);
    assign rule_wdata = '{src: r_from, tgt: r_to, ev: r_ev};
    assign tcfg_wdata = '{src: r_from, tgt: r_to, delay: r_ivl};
    assign elapsed    = r_now - tstart_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= RET_DONE;
            r_cur       <= '0;
            r_started   <= 1'b0;
            r_pend_vld  <= 1'b0;
            r_pend_slot <= '0;
            r_hold_vld  <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_cur       <= n_cur;
            r_started   <= n_started;
            r_pend_vld  <= n_pend_vld;
            r_pend_slot <= n_pend_slot;
            r_hold_vld  <= n_hold_vld;
            r_out_vld   <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_now      <= n_now;
        r_ev       <= n_ev;
        r_idx      <= n_idx;
        r_from     <= n_from;
        r_to       <= n_to;
        r_ivl      <= n_ivl;
        r_any      <= n_any;
        r_ri       <= n_ri;
        r_ti       <= n_ti;
        r_tj       <= n_tj;
        r_hit      <= n_hit;
        r_hit_rule <= n_hit_rule;
        r_hit_slot <= n_hit_slot;
        r_hold     <= n_hold;
        r_out      <= n_out;
    end

    always_comb begin
        n_op        = r_op;
        n_now       = r_now;
        n_ev        = r_ev;
        n_idx       = r_idx;
        n_from      = r_from;
        n_to        = r_to;
        n_ivl       = r_ivl;
        n_any       = r_any;
        n_state     = r_state;
        n_ret       = r_ret;
        n_cur       = r_cur;
        n_started   = r_started;
        n_pend_vld  = r_pend_vld;
        n_pend_slot = r_pend_slot;
        n_ri        = r_ri;
        n_ti        = r_ti;
        n_tj        = r_tj;
        n_hit       = r_hit;
        n_hit_rule  = r_hit_rule;
        n_hit_slot  = r_hit_slot;
        n_hold_vld  = r_hold_vld;
        n_hold      = r_hold;
        n_out_vld   = 1'b0;
        n_out       = r_out;

        rule_we      = 1'b0;
        rule_raddr   = r_ri[RAW-1:0];
        tcfg_we      = 1'b0;
        tstart_we    = 1'b0;
        t_waddr      = r_ti[TAW-1:0];
        t_raddr      = r_ti[TAW-1:0];
        tstart_wdata = r_now;

        do_goto = 1'b0;
        g_src   = '0;
        g_tgt   = '0;
        g_slot  = '0;
        g_timed = 1'b0;
        g_ret   = RET_DONE;
        e_req   = 1'b0;
        e_res   = '0;
        e_res.present = r_cur;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op    = t_op'(i_op);
                    n_now   = i_now_ms;
                    n_ev    = i_event_code;
                    n_idx   = i_entry_index;
                    n_from  = i_from_state;
                    n_to    = i_to_state;
                    n_ivl   = i_interval_ms;
                    n_any   = i_any_target;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_ri    = '0;
                n_ti    = '0;
                n_tj    = '0;
                n_hit   = 1'b0;
                n_state = S_FLUSH;
                case (r_op)
                    OP_LOAD_RULE: begin
                        rule_we = (32'(r_idx) < NUM_RULES);
                    end
                    OP_LOAD_TIMED: begin
                        tcfg_we      = (32'(r_idx) < NUM_TIMED);
                        tstart_we    = tcfg_we;
                        t_waddr      = TAW'(r_idx);
                        tstart_wdata = 32'd0;
                    end
                    OP_FIRE, OP_QUEUE, OP_QUERY: begin
                        if (!r_started || rcnt == '0) n_state = S_SDONE;
                        else                          n_state = S_SRCH_RD;
                    end
                    OP_RUN: begin
                        if (!r_started) begin
                            n_started  = 1'b1;
                            e_req      = 1'b1;
                            e_res.kind = KIND_FIRST;
                        end
                        n_state = S_ACT;
                    end
                    OP_REARM: begin
                        n_ret = RET_DONE;
                        if (tcnt != '0) n_state = S_SWP_RD;
                    end
                    default: ;
                endcase
            end
            S_SRCH_RD: begin
                n_state = S_SRCH_EV;
            end
            S_SRCH_EV: begin
                if (rule_rdata.src == r_cur && rule_rdata.ev == r_ev) begin
                    n_hit      = 1'b1;
                    n_hit_rule = rule_rdata;
                    n_hit_slot = r_ri[RAW-1:0];
                    n_state    = S_SDONE;
                end else begin
                    n_ri = RCW'(r_ri + 1'b1);
                    if (n_ri == rcnt) n_state = S_SDONE;
                    else              n_state = S_SRCH_RD;
                end
            end
            S_SDONE: begin
                n_state = S_FLUSH;
                case (r_op)
                    OP_FIRE: begin
                        if (r_hit) begin
                            do_goto = 1'b1;
                            g_src   = r_hit_rule.src;
                            g_tgt   = r_hit_rule.tgt;
                            g_slot  = 4'(r_hit_slot);
                            g_ret   = RET_DONE;
                        end
                    end
                    OP_QUEUE: begin
                        if (r_hit) begin
                            n_pend_vld  = 1'b1;
                            n_pend_slot = r_hit_slot;
                        end
                    end
                    OP_QUERY: begin
                        e_req        = 1'b1;
                        e_res.kind   = KIND_QUERY;
                        e_res.answer = r_hit;
                    end
                    default: ;
                endcase
            end
            S_ACT: begin
                e_req      = 1'b1;
                e_res.kind = KIND_ACT;
                if (r_pend_vld) n_state = S_PEND_RD;
                else if (tcnt == '0) n_state = S_FLUSH;
                else n_state = S_TSCAN_RD;
            end
            S_PEND_RD: begin
                rule_raddr = r_pend_slot;
                n_state    = S_PEND_EV;
            end
            S_PEND_EV: begin
                n_pend_vld  = 1'b0;
                n_pend_slot = '0;
                do_goto     = 1'b1;
                g_src       = rule_rdata.src;
                g_tgt       = rule_rdata.tgt;
                g_slot      = 4'(r_pend_slot);
                g_ret       = RET_TSCAN;
            end
            S_TSCAN_RD: begin
                n_state = S_TSCAN_EV;
            end
            S_TSCAN_EV: begin
                if (tcfg_rdata.src == r_cur && tstart_rdata == 32'd0) begin
                    tstart_we = 1'b1;
                end
                if (tcfg_rdata.src == r_cur && tstart_rdata != 32'd0
                        && elapsed >= tcfg_rdata.delay) begin
                    do_goto = 1'b1;
                    g_src   = tcfg_rdata.src;
                    g_tgt   = tcfg_rdata.tgt;
                    g_slot  = 4'(r_ti);
                    g_timed = 1'b1;
                    g_ret   = RET_TZERO;
                end else begin
                    n_ti = TCW'(r_ti + 1'b1);
                    if (n_ti == tcnt) n_state = S_FLUSH;
                    else              n_state = S_TSCAN_RD;
                end
            end
            S_TZERO: begin
                // the taken timed rule disarms after its re-arm sweep
                tstart_we    = 1'b1;
                tstart_wdata = 32'd0;
                n_ti = TCW'(r_ti + 1'b1);
                if (n_ti == tcnt) n_state = S_FLUSH;
                else              n_state = S_TSCAN_RD;
            end
            S_SWP_RD: begin
                t_raddr = r_tj[TAW-1:0];
                n_state = S_SWP_EV;
            end
            S_SWP_EV: begin
                t_waddr   = r_tj[TAW-1:0];
                tstart_we = (tcfg_rdata.src == r_cur) &&
                            (r_op != OP_REARM || r_any || tcfg_rdata.tgt == r_to);
                n_tj = TCW'(r_tj + 1'b1);
                if (n_tj != tcnt) begin
                    n_state = S_SWP_RD;
                end else begin
                    unique case (r_ret)
                        RET_DONE:  n_state = S_FLUSH;
                        RET_TSCAN: begin
                            n_ti    = '0;
                            n_state = S_TSCAN_RD;
                        end
                        RET_TZERO: n_state = S_TZERO;
                        default:   n_state = S_FLUSH;
                    endcase
                end
            end
            S_FLUSH: begin
                if (r_hold_vld) begin
                    n_out_vld   = 1'b1;
                    n_out       = r_hold;
                    n_out.last  = 1'b1;
                    n_hold_vld  = 1'b0;
                end
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        if (do_goto) begin
            e_req         = 1'b1;
            e_res.kind    = KIND_TRANS;
            e_res.left    = g_src;
            e_res.entered = g_tgt;
            e_res.slot    = g_slot;
            e_res.timed   = g_timed;
            e_res.present = g_tgt;
            n_cur         = g_tgt;
            n_tj          = '0;
            n_ret         = g_ret;
            if (tcnt != '0) begin
                n_state = S_SWP_RD;
            end else begin
                unique case (g_ret)
                    RET_DONE:  n_state = S_FLUSH;
                    RET_TSCAN: n_state = S_FLUSH;
                    RET_TZERO: n_state = S_TZERO;
                    default:   n_state = S_FLUSH;
                endcase
            end
        end

        // one result is held back so the final one can carry the last flag
        if (e_req) begin
            if (r_hold_vld) begin
                n_out_vld  = 1'b1;
                n_out      = r_hold;
                n_out.last = 1'b0;
            end
            n_hold     = e_res;
            n_hold_vld = 1'b1;
        end

        if (init_we && !r_started) begin
            n_cur = pwdata[3:0];
        end
    end

    assign o_result_valid  = r_out_vld;
    assign o_kind          = r_out.kind;
    assign o_left_state    = r_out.left;
    assign o_entered_state = r_out.entered;
    assign o_rule_slot     = r_out.slot;
    assign o_was_timed     = r_out.timed;
    assign o_answer        = r_out.answer;
    assign o_present_state = r_out.present;
    assign o_last          = r_out.last;

    `TDEF_ASSERT(a_hold_only_busy, i_clk, i_rst_n, !busy |-> !r_hold_vld, "held result while idle")
    `TDEF_ASSERT(a_last_gap, i_clk, i_rst_n, (r_out_vld && r_out.last) |=> !r_out_vld, "result after last")
    `TDEF_ASSERT(a_query_single, i_clk, i_rst_n, (r_out_vld && r_out.kind == KIND_QUERY) |-> r_out.last, "query answer not last")
    `TDEF_ASSERT(a_first_started, i_clk, i_rst_n, (r_out_vld && r_out.kind == KIND_FIRST) |-> r_started, "first entry before start")

endmodule

// File: rtl/core/tdef_cfg_regs.sv
// APB configuration registers: initial state and the two table counts.
// Depends on tdef_pkg.
module tdef_cfg_regs
    import tdef_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg,
    output logic        o_init_we
);

    t_cfg r_cfg;
    logic wr;
    t_reg idx;

    assign wr        = psel && penable && pwrite;
    assign idx       = t_reg'(paddr[3:2]);
    assign pready    = 1'b1;
    assign o_cfg     = r_cfg;
    assign o_init_we = wr && (idx == REG_INIT_STATE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr) begin
            unique case (idx)
                REG_INIT_STATE: r_cfg.init_state <= pwdata[3:0];
                REG_RULES:      r_cfg.rule_cnt   <= pwdata[4:0];
                REG_TIMED:      r_cfg.timed_cnt  <= pwdata[3:0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_INIT_STATE: prdata = {28'd0, r_cfg.init_state};
            REG_RULES:      prdata = {27'd0, r_cfg.rule_cnt};
            REG_TIMED:      prdata = {28'd0, r_cfg.timed_cnt};
            default:        prdata = '0;
        endcase
    end

endmodule

// File: rtl/core/tdef_rule_mem.sv
// Event rule table: one write port, one read port, registered read data.
// Depends on tdef_pkg.
module tdef_rule_mem
    import tdef_pkg::*;
#(
    parameter int NUM_RULES = NUM_RULES_DEF,
    localparam int RAW = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1
) (
    input  logic           i_clk,
    input  logic           i_we,
    input  logic [RAW-1:0] i_waddr,
    input  t_rule          i_wdata,
    input  logic [RAW-1:0] i_raddr,
    output t_rule          o_rdata
);

    t_rule r_mem [NUM_RULES];
    t_rule r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/tdef_timed_mem.sv
// Timed rule table plus timer start words, one read and one write address.
// Depends on tdef_pkg. Start words read as zero until first written.
module tdef_timed_mem
    import tdef_pkg::*;
#(
    parameter int NUM_TIMED = NUM_TIMED_DEF,
    localparam int TAW = (NUM_TIMED > 1) ? $clog2(NUM_TIMED) : 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_start_we,
    input  logic [TAW-1:0] i_waddr,
    input  t_tcfg          i_wcfg,
    input  logic [31:0]    i_wstart,
    input  logic [TAW-1:0] i_raddr,
    output t_tcfg          o_rcfg,
    output logic [31:0]    o_rstart
);

    t_tcfg       r_cfg_mem   [NUM_TIMED];
    logic [31:0] r_start_mem [NUM_TIMED];
    logic [NUM_TIMED-1:0] r_start_vld;
    t_tcfg       r_rcfg;
    logic [31:0] r_rstart;
    logic        r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_cfg_we) begin
            r_cfg_mem[i_waddr] <= i_wcfg;
        end
        if (i_start_we) begin
            r_start_mem[i_waddr] <= i_wstart;
        end
        r_rcfg   <= r_cfg_mem[i_raddr];
        r_rstart <= r_start_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_vld <= '0;
            r_rvld      <= 1'b0;
        end else begin
            if (i_start_we) begin
                r_start_vld[i_waddr] <= 1'b1;
            end
            r_rvld <= r_start_vld[i_raddr];
        end
    end

    assign o_rcfg   = r_rcfg;
    assign o_rstart = r_rvld ? r_rstart : 32'd0;

endmodule
